>>> design/rmd_pkg.sv
// package for the ripemd-160 hash block: types, constants and round tables
package rmd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [79:0][3:0] SEL_L = {
		4'd13,4'd15,4'd6,4'd11,4'd8,4'd3,4'd1,4'd14,4'd10,4'd2,4'd12,4'd7,4'd9,4'd5,4'd0,4'd4,
		4'd2,4'd6,4'd5,4'd14,4'd15,4'd7,4'd3,4'd13,4'd4,4'd12,4'd8,4'd0,4'd10,4'd11,4'd9,4'd1,
		4'd12,4'd5,4'd11,4'd13,4'd6,4'd0,4'd7,4'd2,4'd1,4'd8,4'd15,4'd9,4'd4,4'd14,4'd10,4'd3,
		4'd8,4'd11,4'd14,4'd2,4'd5,4'd9,4'd0,4'd12,4'd3,4'd15,4'd6,4'd10,4'd1,4'd13,4'd4,4'd7,
		4'd15,4'd14,4'd13,4'd12,4'd11,4'd10,4'd9,4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0};

	localparam logic [79:0][3:0] SEL_R = {
		4'd11,4'd9,4'd3,4'd0,4'd14,4'd13,4'd2,4'd6,4'd7,4'd8,4'd5,4'd1,4'd4,4'd10,4'd15,4'd12,
		4'd14,4'd10,4'd7,4'd9,4'd13,4'd2,4'd12,4'd5,4'd0,4'd15,4'd11,4'd3,4'd1,4'd4,4'd6,4'd8,
		4'd13,4'd4,4'd0,4'd10,4'd2,4'd12,4'd8,4'd11,4'd9,4'd6,4'd14,4'd7,4'd3,4'd1,4'd5,4'd15,
		4'd2,4'd1,4'd9,4'd4,4'd12,4'd8,4'd15,4'd14,4'd10,4'd5,4'd13,4'd0,4'd7,4'd3,4'd11,4'd6,
		4'd12,4'd3,4'd10,4'd1,4'd8,4'd15,4'd6,4'd13,4'd4,4'd11,4'd2,4'd9,4'd0,4'd7,4'd14,4'd5};

	localparam logic [79:0][3:0] ROT_L = {
		4'd6,4'd5,4'd8,4'd11,4'd14,4'd13,4'd12,4'd5,4'd12,4'd13,4'd8,4'd6,4'd11,4'd5,4'd15,4'd9,
		4'd12,4'd5,4'd6,4'd8,4'd6,4'd5,4'd14,4'd9,4'd8,4'd9,4'd15,4'd14,4'd15,4'd14,4'd12,4'd11,
		4'd5,4'd7,4'd12,4'd5,4'd6,4'd13,4'd8,4'd14,4'd15,4'd13,4'd9,4'd14,4'd7,4'd6,4'd13,4'd11,
		4'd12,4'd13,4'd7,4'd11,4'd9,4'd15,4'd12,4'd7,4'd15,4'd7,4'd9,4'd11,4'd13,4'd8,4'd6,4'd7,
		4'd8,4'd9,4'd7,4'd6,4'd15,4'd14,4'd13,4'd11,4'd9,4'd7,4'd8,4'd5,4'd12,4'd15,4'd14,4'd11};

	localparam logic [79:0][3:0] ROT_R = {
		4'd11,4'd11,4'd13,4'd15,4'd5,4'd6,4'd13,4'd8,4'd6,4'd14,4'd5,4'd12,4'd9,4'd12,4'd5,4'd8,
		4'd8,4'd15,4'd5,4'd12,4'd9,4'd12,4'd9,4'd6,4'd14,4'd6,4'd14,4'd14,4'd11,4'd8,4'd5,4'd15,
		4'd5,4'd7,4'd13,4'd13,4'd14,4'd5,4'd13,4'd12,4'd14,4'd6,4'd6,4'd8,4'd11,4'd15,4'd7,4'd9,
		4'd11,4'd13,4'd15,4'd6,4'd7,4'd12,4'd7,4'd7,4'd11,4'd9,4'd8,4'd12,4'd7,4'd15,4'd13,4'd9,
		4'd6,4'd12,4'd14,4'd14,4'd11,4'd8,4'd7,4'd7,4'd5,4'd15,4'd15,4'd13,4'd11,4'd9,4'd9,4'd8};

	function automatic logic [31:0] k_left(input logic [2:0] j);
		logic [31:0] k;
		unique case (j)
			3'd0:    k = 32'h00000000;
			3'd1:    k = 32'h5A827999;
			3'd2:    k = 32'h6ED9EBA1;
			3'd3:    k = 32'h8F1BBCDC;
			default: k = 32'hA953FD4E;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] k_right(input logic [2:0] j);
		logic [31:0] k;
		unique case (j)
			3'd0:    k = 32'h50A28BE6;
			3'd1:    k = 32'h5C4DD124;
			3'd2:    k = 32'h6D703EF3;
			3'd3:    k = 32'h7A6D76E9;
			default: k = 32'h00000000;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] bool_fn(input logic [2:0] j, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		unique case (j)
			3'd0:    f = x ^ y ^ z;
			3'd1:    f = (x & y) | (~x & z);
			3'd2:    f = (x | ~y) ^ z;
			3'd3:    f = (x & z) | (y & ~z);
			default: f = x ^ (y | ~z);
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

>>> design/ripemd160_hash_top.sv
// ripemd-160 hash top level: byte packing, padding, round sequencer and digest output
// Takes one message byte per transfer; in_ready stays high after a byte that neither ends a
// 64-byte block nor is marked last. Completing a block runs the shared round unit through
// 80 rounds (one left and one right round per step) and then a combine step, during which
// in_ready is low. A last transfer then passes through a padding-byte step and a length-word
// step, and adds one or two padding blocks (two when the length needs a block of
// its own). The five digest words are then offered on the output channel, word 0 first,
// through a single output register; the block accepts the next message once the fifth word
// has been transferred. Message length wraps modulo 2^61 bytes.
module ripemd160_hash_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rmd_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rmd_pkg::out_item_t  out_data
);
	import rmd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROUND = 6'b000010,
		ST_COMB  = 6'b000100,
		ST_PAD   = 6'b001000,
		ST_LEN   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t       state_q;
	logic [31:0]  chain_q [5];
	logic [31:0]  blk_q [16];
	logic [60:0]  count_q;
	logic [31:0]  l_q [5];
	logic [31:0]  r_q [5];
	logic [6:0]   round_q;
	logic         final_q;
	logic         pad_done_q;
	logic         len_done_q;
	logic [2:0]   widx_q;
	logic         oval_q;
	out_item_t    odata_q;

	logic [2:0]   grp;
	logic [31:0]  tl, tr;
	logic [5:0]   pos;
	logic [3:0]   wi;
	logic [1:0]   bi;
	logic         take;
	logic [60:0]  cnt_inc;

	assign grp  = round_q[6:4];
	assign tl = rotl(l_q[0] + bool_fn(grp, l_q[1], l_q[2], l_q[3])
		+ blk_q[SEL_L[round_q]] + k_left(grp), ROT_L[round_q]) + l_q[4];
	assign tr = rotl(r_q[0] + bool_fn(3'd4 - grp, r_q[1], r_q[2], r_q[3])
		+ blk_q[SEL_R[round_q]] + k_right(grp), ROT_R[round_q]) + r_q[4];

	assign pos      = count_q[5:0];
	assign wi       = pos[5:2];
	assign bi       = pos[1:0];
	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign cnt_inc  = count_q + 61'd1;
	assign out_valid = oval_q;
	assign out_data  = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			round_q    <= '0;
			final_q    <= 1'b0;
			pad_done_q <= 1'b0;
			widx_q     <= '0;
			oval_q     <= 1'b0;
			chain_q    <= '{H0, H1, H2, H3, H4};
			blk_q      <= '{default: '0};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (in_data.byte_valid) begin
							blk_q[wi] <= blk_q[wi] | ({24'd0, in_data.data_byte} << {bi, 3'b000});
							count_q <= cnt_inc;
						end
						final_q    <= in_data.last;
						pad_done_q <= 1'b0;
						if (in_data.byte_valid && pos == 6'd63) begin
							state_q <= ST_ROUND;
							round_q <= '0;
							l_q <= chain_q;
							r_q <= chain_q;
						end else if (in_data.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					l_q[0] <= l_q[4]; l_q[4] <= l_q[3]; l_q[3] <= rotl(l_q[2], 4'd10);
					l_q[2] <= l_q[1]; l_q[1] <= tl;
					r_q[0] <= r_q[4]; r_q[4] <= r_q[3]; r_q[3] <= rotl(r_q[2], 4'd10);
					r_q[2] <= r_q[1]; r_q[1] <= tr;
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79)
						state_q <= ST_COMB;
				end
				ST_COMB: begin
					chain_q[0] <= chain_q[1] + l_q[2] + r_q[3];
					chain_q[1] <= chain_q[2] + l_q[3] + r_q[4];
					chain_q[2] <= chain_q[3] + l_q[4] + r_q[0];
					chain_q[3] <= chain_q[4] + l_q[0] + r_q[1];
					chain_q[4] <= chain_q[0] + l_q[1] + r_q[2];
					blk_q <= '{default: '0};
					if (!final_q)
						state_q <= ST_IDLE;
					else if (!pad_done_q)
						state_q <= ST_PAD;
					else if (!len_done_q)
						state_q <= ST_LEN;
					else begin
						state_q <= ST_OUT;
						widx_q  <= '0;
					end
				end
				ST_PAD: begin
					blk_q[wi] <= blk_q[wi] | (32'h80 << {bi, 3'b000});
					pad_done_q <= 1'b1;
					if (pos >= 6'd56) begin
						state_q <= ST_ROUND;
						round_q <= '0;
						l_q <= chain_q;
						r_q <= chain_q;
						final_q <= 1'b1;
					end else
						state_q <= ST_LEN;
				end
				ST_LEN: begin
					blk_q[14] <= {count_q[28:0], 3'b000};
					blk_q[15] <= count_q[60:29];
					state_q <= ST_ROUND;
					round_q <= '0;
					l_q <= chain_q;
					r_q <= chain_q;
				end
				ST_OUT: begin
					if (!oval_q || out_ready) begin
						if (widx_q == 3'd5) begin
							if (out_ready) begin
								oval_q  <= 1'b0;
								state_q <= ST_IDLE;
								chain_q <= '{H0, H1, H2, H3, H4};
								count_q <= '0;
								final_q <= 1'b0;
							end
						end else begin
							oval_q <= 1'b1;
							odata_q.digest_word <= bswap(chain_q[widx_q]);
							odata_q.word_index  <= widx_q;
							odata_q.last_word   <= (widx_q == 3'd4);
							widx_q <= widx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_done_q <= 1'b0;
		else if (state_q == ST_LEN)
			len_done_q <= 1'b1;
		else if (state_q == ST_IDLE)
			len_done_q <= 1'b0;
	end

endmodule
